[hdl/agga_pkg.sv]
// Shared types, constants and helpers for the affine gap alignment scorer.
package agga_pkg;

    localparam int SCORE_BITS  = 24;
    localparam int SYM_BITS    = 5;
    localparam int ROW_BITS    = 8;
    localparam int LEN_BITS    = 9;
    localparam int COUNT_BITS  = 12;
    localparam int TAB_BITS    = 2 * SYM_BITS;
    localparam int MAX_SUBJECT = 256;
    localparam int MAX_PATTERN = 4095;
    localparam int COLGAP_BITS = 28;

    localparam logic signed [31:0] SCORE_MAX = 32'sd8388607;
    localparam logic signed [31:0] SCORE_MIN = -32'sd8388608;

    // Input item kinds
    localparam logic [1:0] KIND_TABLE   = 2'd0;
    localparam logic [1:0] KIND_SUBJECT = 2'd1;
    localparam logic [1:0] KIND_PATTERN = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_GAP_OPEN   = 2'd0;
    localparam logic [1:0] REG_GAP_EXTEND = 2'd1;
    localparam logic [1:0] REG_SUBJ_LEN   = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SYM_BITS-1:0] sym_a;
        logic [SYM_BITS-1:0] sym_b;
        logic [ROW_BITS-1:0] position;
        logic signed [15:0]  score_value;
        logic                first_column;
    } t_cmd;

    typedef struct packed {
        logic                   saturated;
        logic [COUNT_BITS-1:0]  column_index;
        logic signed [SCORE_BITS-1:0] column_score;
    } t_result;

    typedef struct packed {
        logic                         hit;
        logic signed [SCORE_BITS-1:0] value;
    } t_clip;

    // Clip a wide score to 24 bits and report whether it clipped
    function automatic t_clip clip_score(input logic signed [31:0] v);
        t_clip c;
        c.hit = 1'b0;
        c.value = v[SCORE_BITS-1:0];
        if (v > SCORE_MAX) begin
            c.hit = 1'b1;
            c.value = SCORE_MAX[SCORE_BITS-1:0];
        end else if (v < SCORE_MIN) begin
            c.hit = 1'b1;
            c.value = SCORE_MIN[SCORE_BITS-1:0];
        end
        return c;
    endfunction

endpackage

[hdl/agga_queue.sv]
// Four-entry request queue between the front and the back part.
module agga_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  agga_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output agga_pkg::t_cmd o_cmd
);
    import agga_pkg::*;

    t_cmd       r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 3'd4);
    assign o_empty = (r_count == 3'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 2'd1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 2'd1;
            r_count <= r_count + {2'd0, do_push} - {2'd0, do_pop};
        end
    end

endmodule

[hdl/agga_front.sv]
// Front part: takes input requests, unpacks and classifies them, drops unknown kinds.
module agga_front (
    input  logic           i_valid,
    input  logic [39:0]    i_data,
    input  logic [1:0]     i_user,
    output logic           o_ready,
    input  logic           i_queue_full,
    output logic           o_push,
    output agga_pkg::t_cmd o_cmd
);
    import agga_pkg::*;

    logic known;

    // Unpack the request
    always_comb begin
        o_cmd.kind         = i_user;
        o_cmd.sym_a        = i_data[4:0];
        o_cmd.sym_b        = i_data[9:5];
        o_cmd.position     = i_data[17:10];
        o_cmd.score_value  = i_data[33:18];
        o_cmd.first_column = i_data[34];
    end

    // Classify: only table, subject and pattern requests go on
    always_comb begin
        unique case (i_user)
            KIND_TABLE, KIND_SUBJECT, KIND_PATTERN: known = 1'b1;
            default:                                known = 1'b0;
        endcase
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full && known;

endmodule

[hdl/agga_back.sv]
// Back part: score table and subject stores, column pipeline and result register.
module agga_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_empty,
    input  agga_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output agga_pkg::t_result o_result
);
    import agga_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Configuration
    logic signed [15:0]  r_gap_open;
    logic signed [15:0]  r_gap_ext;
    logic [LEN_BITS-1:0] r_subj_len;

    // Stores
    logic signed [15:0]           r_table   [1 << TAB_BITS];
    logic [SYM_BITS-1:0]          r_subject [MAX_SUBJECT];
    logic signed [SCORE_BITS-1:0] r_prev    [MAX_SUBJECT];
    logic signed [SCORE_BITS-1:0] r_rowgap  [MAX_SUBJECT];
    logic [MAX_SUBJECT-1:0]       r_row_ok;

    // Column control
    logic [1:0]                   r_state;
    logic [COUNT_BITS-1:0]        r_counter;
    logic                         r_clip;
    logic                         r_rg_valid;
    logic [SYM_BITS-1:0]          r_sym_a;
    logic [LEN_BITS-1:0]          r_len;
    logic [LEN_BITS-1:0]          r_issue;
    logic signed [15:0]           r_init_go;
    logic signed [15:0]           r_init_ge;
    logic signed [SCORE_BITS-1:0] r_prev0;
    logic signed [SCORE_BITS-1:0] r_diag;
    logic signed [SCORE_BITS-1:0] r_cur;
    logic signed [COLGAP_BITS-1:0] r_colgap;

    // Pipeline stage two
    logic                         r_s2_valid;
    logic [LEN_BITS-1:0]          r_s2_row;
    logic                         r_s2_ok;
    logic signed [25:0]           r_s2_prod;
    logic signed [SCORE_BITS-1:0] r_s2_prev;
    logic signed [SCORE_BITS-1:0] r_s2_rg;
    logic [SYM_BITS-1:0]          r_s2_subj;

    // Pipeline stage three
    logic                         r_s3_valid;
    logic [LEN_BITS-1:0]          r_s3_row;
    logic signed [SCORE_BITS-1:0] r_s3_prev;
    logic signed [SCORE_BITS-1:0] r_s3_rg;
    logic signed [15:0]           r_s3_sub;

    // Result register
    logic                         r_out_valid;
    t_result                      r_out;

    logic                         pop_now;
    logic                         run_start;
    logic [LEN_BITS-1:0]          len_clamped;
    logic                         issue_now;
    logic [ROW_BITS-1:0]          issue_addr;
    logic [ROW_BITS-1:0]          wb_addr;
    logic signed [31:0]           go32;
    logic signed [31:0]           ge32;
    t_clip                        start_clip;
    t_clip                        cur0_clip;
    t_clip                        bnd_clip;
    logic signed [SCORE_BITS-1:0] s2_prev_eff;
    logic signed [SCORE_BITS-1:0] s2_rg_eff;
    logic signed [31:0]           open_row;
    logic signed [31:0]           ext_row;
    t_clip                        rg_clip;
    logic signed [31:0]           open_col;
    logic signed [31:0]           col_ext;
    logic signed [31:0]           colgap_n;
    logic signed [31:0]           diag;
    logic signed [31:0]           best;
    t_clip                        cur_clip;
    logic                         last_row;

    assign go32 = 32'(r_gap_open);
    assign ge32 = 32'(r_gap_ext);

    // Decode requests at the head of the queue
    assign pop_now   = (r_state == ST_IDLE) && !i_empty;
    assign o_pop     = pop_now;
    assign run_start = i_cmd.first_column || (r_counter == '0);

    always_comb begin
        len_clamped = r_subj_len;
        if (r_subj_len == '0) len_clamped = LEN_BITS'(1);
        else if (r_subj_len > LEN_BITS'(MAX_SUBJECT)) len_clamped = LEN_BITS'(MAX_SUBJECT);
    end

    // The deepest boundary cell decides whether run start clips
    assign start_clip = clip_score(go32 + (ge32 <<< ROW_BITS));
    assign cur0_clip  = clip_score(go32 + 32'(signed'({1'b0, r_counter})) * ge32);

    assign issue_now  = (r_state == ST_RUN) && (r_issue <= r_len);
    assign issue_addr = ROW_BITS'(r_issue - LEN_BITS'(1));
    assign wb_addr    = ROW_BITS'(r_s3_row - LEN_BITS'(1));

    // Rows not yet written in this run read as run start values
    assign bnd_clip    = clip_score(32'(r_init_go) + 32'(r_s2_prod));
    assign s2_prev_eff = r_s2_ok ? r_s2_prev : bnd_clip.value;
    assign s2_rg_eff   = r_s2_ok ? r_s2_rg : SCORE_MIN[SCORE_BITS-1:0];

    // Cell update
    always_comb begin
        open_row = 32'(r_s3_prev) + go32 + ge32;
        ext_row  = 32'(r_s3_rg) + ge32;
        if (r_rg_valid && ext_row > open_row) open_row = ext_row;
        rg_clip  = clip_score(open_row);
        open_col = 32'(r_cur) + go32 + ge32;
        col_ext  = 32'(r_colgap) + ge32;
        colgap_n = (r_s3_row == LEN_BITS'(1) || open_col > col_ext) ? open_col : col_ext;
        diag     = 32'(r_diag) + 32'(r_s3_sub);
        best     = 32'(rg_clip.value);
        if (colgap_n > best) best = colgap_n;
        if (diag > best) best = diag;
        cur_clip = clip_score(best);
        last_row = (r_s3_row == r_len);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_open <= -16'sd10;
            r_gap_ext  <= -16'sd1;
            r_subj_len <= LEN_BITS'(MAX_SUBJECT);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_GAP_OPEN:   r_gap_open <= i_cfg_data;
                REG_GAP_EXTEND: r_gap_ext  <= i_cfg_data;
                REG_SUBJ_LEN:   r_subj_len <= i_cfg_data[LEN_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Table and subject stores
    always_ff @(posedge i_clk) begin
        if (pop_now && i_cmd.kind == KIND_TABLE) begin
            r_table[{i_cmd.sym_a, i_cmd.sym_b}] <= i_cmd.score_value;
        end
        if (pop_now && i_cmd.kind == KIND_SUBJECT) begin
            r_subject[i_cmd.position] <= i_cmd.sym_b;
        end
        if (issue_now) begin
            r_s2_subj <= r_subject[issue_addr];
        end
        if (r_s2_valid) begin
            r_s3_sub <= r_table[{r_sym_a, r_s2_subj}];
        end
    end

    // Column stores: read ahead, write back
    always_ff @(posedge i_clk) begin
        if (issue_now) begin
            r_s2_prev <= r_prev[issue_addr];
            r_s2_rg   <= r_rowgap[issue_addr];
        end
        if (r_s3_valid) begin
            r_prev[wb_addr]   <= cur_clip.value;
            r_rowgap[wb_addr] <= rg_clip.value;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (issue_now) begin
            r_s2_row  <= r_issue;
            r_s2_ok   <= r_row_ok[issue_addr];
            r_s2_prod <= 26'(signed'({1'b0, r_issue}) * r_init_ge);
        end
        if (r_s2_valid) begin
            r_s3_row  <= r_s2_row;
            r_s3_prev <= s2_prev_eff;
            r_s3_rg   <= s2_rg_eff;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_counter   <= '0;
            r_clip      <= 1'b0;
            r_rg_valid  <= 1'b0;
            r_row_ok    <= '0;
            r_prev0     <= '0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_issue     <= '0;
        end else begin
            r_s2_valid <= issue_now;
            r_s3_valid <= r_s2_valid;
            if (r_out_valid && i_ready && r_state != ST_DONE) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (pop_now && i_cmd.kind == KIND_PATTERN) begin
                        r_sym_a <= i_cmd.sym_a;
                        r_len   <= len_clamped;
                        if (run_start) begin
                            r_counter  <= COUNT_BITS'(1);
                            r_clip     <= start_clip.hit;
                            r_rg_valid <= 1'b0;
                            r_row_ok   <= '0;
                            r_prev0    <= '0;
                            r_init_go  <= r_gap_open;
                            r_init_ge  <= r_gap_ext;
                        end else if (r_counter != COUNT_BITS'(MAX_PATTERN)) begin
                            r_counter <= r_counter + COUNT_BITS'(1);
                        end
                        r_state <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    r_cur   <= cur0_clip.value;
                    r_diag  <= r_prev0;
                    r_prev0 <= cur0_clip.value;
                    r_clip  <= r_clip | cur0_clip.hit;
                    r_issue <= LEN_BITS'(1);
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (issue_now) r_issue <= r_issue + LEN_BITS'(1);
                    if (r_s3_valid) begin
                        r_cur    <= cur_clip.value;
                        r_colgap <= COLGAP_BITS'(colgap_n);
                        r_diag   <= r_s3_prev;
                        r_clip   <= r_clip | rg_clip.hit | cur_clip.hit;
                        r_row_ok[wb_addr] <= 1'b1;
                        if (last_row) begin
                            r_rg_valid <= 1'b1;
                            r_state    <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    // Hold the column until the result register is free
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_out_valid || i_ready)) begin
            r_out.column_score <= r_cur;
            r_out.column_index <= r_counter;
            r_out.saturated    <= r_clip;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[hdl/affine_gap_global_alignment_scorer.sv]
// Top level of the affine gap global alignment scorer.
// Score table entries (kind 0) and subject symbols (kind 1) go straight into the back
// part's stores. A pattern symbol (kind 2) computes one column: one cell a cycle through
// a three-stage read/compute pipeline over the column stores. Requests queue up to four
// deep ahead of the column engine; a finished column score waits in the output register
// while the next column runs. Stores need no clearing after reset; the score table and
// subject must be loaded before they are read.
module affine_gap_global_alignment_scorer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // first_symbol[4:0], second_symbol[9:5], position[17:10], score_value[33:18],
    // first_column[34], zero fill[39:35]
    input  logic [39:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // column_score[23:0], column_index[35:24], saturated[36], zero fill[39:37]
    output logic [39:0] m_axis_tdata
);
    import agga_pkg::*;

    t_cmd    push_cmd;
    t_cmd    head_cmd;
    logic    push;
    logic    full;
    logic    empty;
    logic    pop;
    t_result result;

    agga_front u_front (
        .i_valid      (s_axis_tvalid),
        .i_data       (s_axis_tdata),
        .i_user       (s_axis_tuser),
        .o_ready      (s_axis_tready),
        .i_queue_full (full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    agga_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    agga_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_empty     (empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {3'd0, result.saturated, result.column_index, result.column_score};

endmodule
